// File: rtl/rpn_stack_calculator_core_assert.svh
// Assertion macros for the RPN calculator core
`ifndef RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`define RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RPN_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication: consequent checked in the cycle after the antecedent
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the RPN stack calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpn_pkg;
  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_REM   = 3'd5;
  localparam logic [2:0] CMD_PRINT = 3'd6;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               printed;
    logic               underflow;
    logic               overflow;
    logic               divide_by_zero;
    logic               saturated;
  } rpn_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POPB, ST_WAITB, ST_POPA, ST_WAITA, ST_EXEC, ST_DIVRUN,
    ST_FIN, ST_PUSH, ST_OUT
  } rpn_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input item, clear flags
    logic rd_b;        // read top into b (or zero+underflow)
    logic lat_b;       // latch read data into b
    logic rd_a;
    logic lat_a;
    logic exec;        // start arithmetic
    logic div_step;    // one divider iteration
    logic finish;      // form result from arithmetic
    logic push;        // push result or operand
    logic push_operand;
  } rpn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic b_zero;
  } rpn_stat_t;
endpackage

// File: rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Command sequencer: pops, arithmetic, divider iterations, push, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpn_ctrl import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [2:0] in_cmd,
  input  logic       out_fire,
  input  rpn_stat_t  stat,
  output rpn_cmd_t   cmd,
  output logic       busy,
  output logic       out_valid
);
  rpn_state_t state, state_next;
  logic [2:0] op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= CMD_PUSH;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    out_valid  = (state == ST_OUT);
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          op_next     = in_cmd;
          case (in_cmd)
            CMD_PUSH: state_next = ST_PUSH;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM, CMD_PRINT:
              state_next = ST_POPB;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_POPB: begin
        cmd.rd_b = 1'b1; state_next = ST_WAITB;
      end
      ST_WAITB: begin
        cmd.lat_b = 1'b1;
        if (op == CMD_PRINT) state_next = ST_OUT;
        else state_next = ST_POPA;
      end
      ST_POPA: begin
        if ((op == CMD_DIV || op == CMD_REM) && stat.b_zero) state_next = ST_OUT;
        else begin
          cmd.rd_a = 1'b1; state_next = ST_WAITA;
        end
      end
      ST_WAITA: begin
        cmd.lat_a = 1'b1; state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (op == CMD_DIV || op == CMD_REM) state_next = ST_DIVRUN;
        else state_next = ST_FIN;
      end
      ST_DIVRUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1; state_next = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        cmd.push_operand = (op == CMD_PUSH);
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/rpn_dp.sv
// ----------------------------------------------------------------------------
// rpn_dp
// Stack RAM, pointer, operand registers, saturating ALU, radix-2 divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpn_dp import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  rpn_in_t  in_item,
  input  rpn_cmd_t cmd,
  output rpn_stat_t stat,
  output rpn_out_t out_item
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);
  localparam logic signed [63:0] MAX32 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] MIN32 = -64'sh0000_0000_8000_0000;

  logic [PW-1:0] sp;
  logic [2:0]    op;
  logic signed [31:0] operand, a, b, res;
  logic b_valid, a_valid;
  logic f_under, f_over, f_sat, f_dz;
  logic signed [63:0] wide;    // registered product/sum
  logic [47:0] rem_q;          // divider quotient / shift register
  logic [32:0] rem_r;          // partial remainder
  logic [5:0]  div_cnt;
  logic        neg_q, neg_r;
  logic [31:0] bmag;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] rdata;
  logic we;

  assign raddr = AW'(sp - PW'(1));
  assign waddr = AW'(sp);
  assign we    = cmd.push && (sp != FULL);

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we, .waddr,
    .wdata(cmd.push_operand ? operand : res),
    .raddr, .rdata
  );

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v,
                                               output logic s);
    s = 1'b0;
    if (v > MAX32) begin s = 1'b1; return 32'sh7fff_ffff; end
    if (v < MIN32) begin s = 1'b1; return 32'sh8000_0000; end
    return v[31:0];
  endfunction

  logic [32:0] trial;
  logic signed [63:0] qs, rs;
  logic sat_c;
  logic signed [31:0] fin_val;

  assign trial = {rem_r[31:0], rem_q[47]} - {1'b0, bmag};

  always_comb begin
    qs = neg_q ? -$signed({16'd0, rem_q}) : $signed({16'd0, rem_q});
    rs = neg_r ? -$signed({31'd0, rem_r}) : $signed({31'd0, rem_r});
    sat_c = 1'b0;
    fin_val = '0;
    case (op)
      CMD_ADD, CMD_SUB: fin_val = clamp(wide, sat_c);
      CMD_MUL:          fin_val = clamp(wide >>> 16, sat_c);
      CMD_DIV:          fin_val = clamp(qs, sat_c);
      CMD_REM:          fin_val = rs[31:0];
      default:          fin_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else begin
      if (cmd.rd_b || cmd.rd_a) begin
        if (sp != '0) sp <= sp - PW'(1);
      end else if (we) sp <= sp + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= in_item.command; operand <= in_item.operand_value;
      f_under <= 1'b0; f_over <= 1'b0; f_sat <= 1'b0; f_dz <= 1'b0;
    end
    if (cmd.rd_b) begin
      b_valid <= (sp != '0);
      if (sp == '0) f_under <= 1'b1;
    end
    if (cmd.rd_a) begin
      a_valid <= (sp != '0);
      if (sp == '0) f_under <= 1'b1;
    end
    if (cmd.lat_b) b <= b_valid ? $signed(rdata) : '0;
    if (cmd.lat_a) a <= a_valid ? $signed(rdata) : '0;
    if (cmd.lat_b && (op == CMD_DIV || op == CMD_REM) &&
        (!b_valid || rdata == '0)) f_dz <= 1'b1;
    if (cmd.exec) begin
      case (op)
        CMD_ADD: wide <= 64'(a) + 64'(b);
        CMD_SUB: wide <= 64'(a) - 64'(b);
        CMD_MUL: wide <= a * b;
        default: wide <= '0;
      endcase
      // remainder stops after the 32 dividend bits
      rem_q   <= {a[31] ? 32'(-a) : 32'(a), 16'd0};
      rem_r   <= '0;
      bmag    <= b[31] ? 32'(-b) : 32'(b);
      neg_q   <= a[31] ^ b[31];
      neg_r   <= a[31];
      div_cnt <= (op == CMD_REM) ? 6'd32 : 6'd48;
    end
    if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - 6'd1;
      if (!trial[32]) begin
        rem_r <= trial;
        rem_q <= {rem_q[46:0], 1'b1};
      end else begin
        rem_r <= {rem_r[31:0], rem_q[47]};
        rem_q <= {rem_q[46:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      res <= fin_val;
      if (sat_c) f_sat <= 1'b1;
    end
    if (cmd.push && sp == FULL) f_over <= 1'b1;
  end

  assign stat.div_done = (div_cnt == 6'd1);
  assign stat.b_zero   = (b == '0);

  always_comb begin
    out_item = '0;
    out_item.printed        = (op == CMD_PRINT);
    out_item.result_value   = (op == CMD_PRINT) ? b : '0;
    out_item.underflow      = f_under;
    out_item.overflow       = f_over;
    out_item.divide_by_zero = f_dz;
    out_item.saturated      = f_sat;
  end
endmodule

// File: rtl/rpn_stack_calculator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Reverse Polish calculator on a stack of signed Q16.16 values.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/in_stall  | rpn_in_t (command, operand_value)
// out     | output    | out_valid/out_stall| rpn_out_t (value and flags)
//
// One item at a time: a new item is taken only after the result of the
// last one has been taken. The divider loop (one quotient bit a cycle, 32
// bits for remainder, 48 for divide) sets the worst case. Reset (rst,
// synchronous) empties the stack at once; no clearing pass. in_stall is
// high while an item is in work; a stalled result simply holds in the
// output state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpn_stack_calculator_core import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rpn_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output rpn_out_t out_item
);
  `include "rpn_stack_calculator_core_assert.svh"

  rpn_cmd_t  cmd;
  rpn_stat_t stat;
  logic busy, in_fire, out_fire;

  // accept only while idle
  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_fire = out_valid && !out_stall;

  rpn_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_cmd(in_item.command), .out_fire,
    .stat, .cmd, .busy, .out_valid
  );

  rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk, .rst, .in_item, .cmd, .stat, .out_item
  );

  `RPN_ASSERT_IMPL(a_no_accept_busy, out_valid, in_stall, "item accepted during output")
  `RPN_ASSERT_NEXT(a_out_done, out_fire, !out_valid, "result repeated")
  `RPN_ASSERT_IMPL(a_push_pop_excl, cmd.push, !(cmd.rd_a || cmd.rd_b), "push and pop clash")
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives RPN commands into the calculator core and checks each result item
// against a behavioral model of the value stack held in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import rpn_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [2:0] CMD_NONE = 3'd7;  // undefined command: stack untouched, all-zero result

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rpn_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rpn_out_t out_item;

  // model state
  logic signed [31:0] calc_stack [DEPTH];
  int                 calc_depth = 0;
  rpn_out_t           pending_results [$];
  int                 error_count = 0;
  bit                 gaps_on = 1'b0;
  bit                 hold_off = 1'b0;
  int                 burst_left = 0;

  rpn_stack_calculator_core #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #10 clk = ~clk;

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // model: one command in, one result out
  function automatic rpn_out_t calc_result(rpn_in_t cmd);
    rpn_out_t           r;
    logic signed [31:0] a, b;
    logic signed [63:0] wide;
    r = '0;
    a = '0;
    b = '0;
    case (cmd.command)
      CMD_PUSH: begin
        if (calc_depth < DEPTH) begin
          calc_stack[calc_depth] = cmd.operand_value;
          calc_depth++;
        end else r.overflow = 1'b1;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: begin
        if (calc_depth > 0) begin
          calc_depth--;
          b = calc_stack[calc_depth];
        end else r.underflow = 1'b1;
        if ((cmd.command == CMD_DIV || cmd.command == CMD_REM) && b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          if (calc_depth > 0) begin
            calc_depth--;
            a = calc_stack[calc_depth];
          end else r.underflow = 1'b1;
          case (cmd.command)
            CMD_ADD: wide = 64'(a) + 64'(b);
            CMD_SUB: wide = 64'(a) - 64'(b);
            CMD_MUL: wide = (64'(a) * 64'(b)) >>> 16;  // floor
            CMD_DIV: wide = (64'(a) <<< 16) / 64'(b);  // toward zero
            default: wide = 64'(a) % 64'(b);
          endcase
          if (wide > 64'sh7FFF_FFFF) begin
            wide = 64'sh7FFF_FFFF;
            r.saturated = 1'b1;
          end else if (wide < -64'sh8000_0000) begin
            wide = -64'sh8000_0000;
            r.saturated = 1'b1;
          end
          calc_stack[calc_depth] = wide[31:0];
          calc_depth++;
        end
      end
      CMD_PRINT: begin
        r.printed = 1'b1;
        if (calc_depth > 0) begin
          calc_depth--;
          r.result_value = calc_stack[calc_depth];
        end else r.underflow = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one command; bursts and gaps when gaps are on
  // valid stays up after acceptance so the next item can follow at once
  task automatic send_cmd(input logic [2:0] c, input logic signed [31:0] v);
    rpn_in_t item;
    item.command = c;
    item.operand_value = v;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(calc_result(item));
    if (burst_left > 0) burst_left--;
  endtask

  // drop valid after the last item of a sequence
  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (gaps_on) out_stall <= ($urandom_range(3) == 0);
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    rpn_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with none expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.result_value !== want.result_value) begin
          $error("result_value exp %h got %h", want.result_value, out_item.result_value);
          error_count++;
        end
        if (out_item.printed !== want.printed) begin
          $error("printed exp %b got %b", want.printed, out_item.printed);
          error_count++;
        end
        if (out_item.underflow !== want.underflow) begin
          $error("underflow exp %b got %b", want.underflow, out_item.underflow);
          error_count++;
        end
        if (out_item.overflow !== want.overflow) begin
          $error("overflow exp %b got %b", want.overflow, out_item.overflow);
          error_count++;
        end
        if (out_item.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero exp %b got %b", want.divide_by_zero,
                 out_item.divide_by_zero);
          error_count++;
        end
        if (out_item.saturated !== want.saturated) begin
          $error("saturated exp %b got %b", want.saturated, out_item.saturated);
          error_count++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(8));
      3: return 32'($signed($urandom) >>> $urandom_range(31));
      default: return 32'($urandom);
    endcase
  endfunction

  // extremes, each operation, empty stack, zero divisor
  task automatic test_directed();
    send_cmd(CMD_PRINT, 0);                       // print on empty
    send_cmd(CMD_ADD, 0);                         // binary op on empty
    send_cmd(CMD_PRINT, 0);
    send_cmd(CMD_PUSH, 32'sh7FFF_FFFF);
    send_cmd(CMD_PUSH, 32'sh7FFF_FFFF);
    send_cmd(CMD_ADD, 0);                         // saturates high
    send_cmd(CMD_PUSH, 32'sh8000_0000);
    send_cmd(CMD_SUB, 0);                         // saturates high
    send_cmd(CMD_PUSH, 32'sh0003_0000);
    send_cmd(CMD_MUL, 0);                         // saturates
    send_cmd(CMD_PUSH, 32'sh0000_0000);
    send_cmd(CMD_DIV, 0);                         // zero divisor
    send_cmd(CMD_PUSH, 32'shFFFF_8000);
    send_cmd(CMD_DIV, 0);                         // quotient clamps
    send_cmd(CMD_PUSH, 32'sh0000_7000);
    send_cmd(CMD_REM, 0);
    send_cmd(CMD_PRINT, 0);
    send_cmd(CMD_DIV, 0);                         // empty divisor
    send_cmd(CMD_NONE, 32'shFFFF_FFFF);           // ignored command
    send_cmd(CMD_PUSH, 32'shFFFF_0000);
    send_cmd(CMD_PUSH, 32'sh0002_8000);
    send_cmd(CMD_REM, 0);
    send_cmd(CMD_PRINT, 0);
  endtask

  // fill past full, binary op at full, then drain
  task automatic test_full_stack();
    repeat (DEPTH + 2) send_cmd(CMD_PUSH, rand_value());
    send_cmd(CMD_MUL, 0);
    repeat (DEPTH + 1) send_cmd(CMD_PRINT, 0);
  endtask

  // receiver holds off while commands keep coming, so the core backs up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (8) send_cmd(CMD_PUSH, rand_value());
        idle_input();
      end
    join
  endtask

  // mostly well-formed expressions with random values, some noise
  task automatic test_random();
    int n;
    logic [2:0] op;
    n = 0;
    while (n < 280) begin
      if ($urandom_range(9) == 0) begin
        send_cmd(3'($urandom_range(7)), rand_value());
        n++;
      end else begin
        send_cmd(CMD_PUSH, rand_value());
        send_cmd(CMD_PUSH, rand_value());
        op = 3'($urandom_range(CMD_ADD, CMD_REM));
        send_cmd(op, 0);
        n += 3;
        if ($urandom_range(1)) begin
          send_cmd(CMD_PRINT, 0);
          n++;
        end
      end
      if ((n % 100) < 4) gaps_on = ~gaps_on;
    end
    while (calc_depth > 0) send_cmd(CMD_PRINT, 0);
    idle_input();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    gaps_on = 1'b1;
    test_full_stack();
    test_backpressure();
    test_random();
    gaps_on = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_ctrl.sv
rtl/rpn_dp.sv
rtl/rpn_stack_calculator_core.sv
tb/testbench.sv
